[rtl/pci_config_space_unit_defines.svh]
// ----------------------------------------------------------------------------
// PCI configuration space unit assertion macros
// Shared property forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PCI_CONFIG_SPACE_UNIT_DEFINES_SVH
`define PCI_CONFIG_SPACE_UNIT_DEFINES_SVH

// same-cycle implication
`define PCS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcs assertion failed");

// next-cycle implication
`define PCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcs assertion failed");

`endif

[rtl/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, constants and helpers of the PCI configuration space unit.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int FUNCTIONS = 1;
   localparam int NREG      = 7;
   localparam int NEV       = 2 * NREG;
   localparam int DEPTH     = FUNCTIONS * 64;
   localparam int AW        = $clog2(DEPTH);

   typedef logic [AW-1:0] addr_type;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [2:0] CSR_ID      = 3'd0;
   localparam logic [2:0] CSR_CLASS   = 3'd1;
   localparam logic [2:0] CSR_FLAGS   = 3'd2;
   localparam logic [2:0] CSR_CODES   = 3'd3;
   localparam logic [2:0] CSR_DEF01   = 3'd4;
   localparam logic [2:0] CSR_DEF23   = 3'd5;
   localparam logic [2:0] CSR_DEF45   = 3'd6;
   localparam logic [2:0] CSR_DEFROM  = 3'd7;

   localparam logic [2:0]  ROM_REG      = 3'd6;
   localparam logic [31:0] MASK_MEM     = 32'hFFFFFFF0;
   localparam logic [31:0] MASK_IO      = 32'hFFFFFFFC;
   localparam logic [31:0] ROM_ADDR     = 32'hFFFFF800;
   localparam logic [31:0] ROM_KEEP_OLD = 32'h000007FE;
   localparam logic [31:0] ROM_KEEP_NEW = 32'hFFFFF801;
   localparam logic [31:0] ROM_LOW      = 32'h000007FF;
   localparam logic [7:0]  KEEP_MEM     = 8'hF0;
   localparam logic [7:0]  KEEP_IO      = 8'hFC;

   typedef struct packed {
      logic [31:0] id_word;
      logic [31:0] class_word;
      logic [18:0] region_flags;
      logic [34:0] size_codes;
      logic [63:0] def01;
      logic [63:0] def23;
      logic [63:0] def45;
      logic [31:0] defrom;
   } cfg_type;

   typedef enum logic [1:0] {ACT_NONE, ACT_READ, ACT_RMW, ACT_RESET} act_type;
   typedef enum logic [1:0] {EVM_CMD, EVM_BAR, EVM_ROM, EVM_RST} evm_type;

   typedef struct packed {
      logic accept;
      logic rd_ofs;
      logic rd_reg;
      logic wr_mod;
      logic wr_def;
      logic clr_fn;
      logic emit_rd;
      logic emit_ev;
      logic emit_empty;
   } ctrl_type;

   typedef struct packed {
      act_type act;
      logic    mod_events;
      logic    ev_last;
      logic    out_free;
   } status_type;

   function automatic logic read_only(input logic [7:0] off);
      return (off inside {[8'h00:8'h03], [8'h08:8'h0F], [8'h2C:8'h2F],
                          [8'h34:8'h3B], 8'h3E, 8'h3F});
   endfunction

   function automatic logic clears_on_reset(input logic [5:0] dw);
      return (dw inside {6'd1, [6'd4:6'd10], 6'd12, [6'd16:6'd63]});
   endfunction

   function automatic logic [5:0] dword_of(input logic [2:0] r);
      return (r == ROM_REG) ? 6'd12 : 6'd4 + 6'(r);
   endfunction

   function automatic addr_type addr_of(input logic [2:0] fn, input logic [5:0] dw);
      return addr_type'({fn, dw});
   endfunction

   function automatic logic [31:0] align_mask(input logic [4:0] code);
      return ~32'h0 << code;
   endfunction

   function automatic logic [31:0] put_byte(input logic [31:0] d, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = d;
      r[8*lane +: 8] = b;
      return r;
   endfunction

endpackage

[rtl/pcs_csr.sv]
// ----------------------------------------------------------------------------
// pcs_csr
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module pcs_csr
   import pcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       we;

   assign idx    = paddr[5:3];
   assign we     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (we) begin
         case (idx)
            CSR_ID:     cfg_in.id_word      = pwdata[31:0];
            CSR_CLASS:  cfg_in.class_word   = pwdata[31:0];
            CSR_FLAGS:  cfg_in.region_flags = pwdata[18:0];
            CSR_CODES:  cfg_in.size_codes   = pwdata[34:0];
            CSR_DEF01:  cfg_in.def01        = pwdata;
            CSR_DEF23:  cfg_in.def23        = pwdata;
            CSR_DEF45:  cfg_in.def45        = pwdata;
            default:    cfg_in.defrom       = pwdata[31:0];
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_ID:     prdata = {32'h0, cfg_ff.id_word};
         CSR_CLASS:  prdata = {32'h0, cfg_ff.class_word};
         CSR_FLAGS:  prdata = {45'h0, cfg_ff.region_flags};
         CSR_CODES:  prdata = {29'h0, cfg_ff.size_codes};
         CSR_DEF01:  prdata = cfg_ff.def01;
         CSR_DEF23:  prdata = cfg_ff.def23;
         CSR_DEF45:  prdata = cfg_ff.def45;
         default:    prdata = {32'h0, cfg_ff.defrom};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/pcs_ctrl.sv]
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: fetch, modify, default load and region event steps.
// ----------------------------------------------------------------------------
module pcs_ctrl
   import pcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output ctrl_type   ctl
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_MODIFY, ST_LOAD, ST_EVREAD, ST_EVOUT, ST_EMPTY
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            case (sts.act)
               ACT_READ, ACT_RMW: begin
                  ctl.rd_ofs = 1'b1;
                  state_in   = ST_MODIFY;
               end
               ACT_RESET: begin
                  ctl.clr_fn = 1'b1;
                  state_in   = sts.mod_events ? ST_LOAD : ST_EMPTY;
               end
               default: state_in = ST_EMPTY;
            endcase
         end
         ST_MODIFY: begin
            if (sts.act == ACT_READ) begin
               if (sts.out_free) begin
                  ctl.emit_rd = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               ctl.wr_mod = 1'b1;
               state_in   = sts.mod_events ? ST_EVREAD : ST_EMPTY;
            end
         end
         ST_LOAD: begin
            ctl.wr_def = 1'b1;
            state_in   = ST_EVREAD;
         end
         ST_EVREAD: begin
            ctl.rd_reg = 1'b1;
            state_in   = ST_EVOUT;
         end
         ST_EVOUT: begin
            if (sts.out_free) begin
               ctl.emit_ev = 1'b1;
               if (sts.ev_last) state_in = ST_IDLE;
               else state_in = (sts.act == ACT_RESET) ? ST_LOAD : ST_EVREAD;
            end
         end
         ST_EMPTY: begin
            if (sts.out_free) begin
               ctl.emit_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/pcs_dp.sv]
// ----------------------------------------------------------------------------
// pcs_dp
// Datapath: request latch, dword store, byte merge, event list, result word.
// ----------------------------------------------------------------------------
module pcs_dp
   import pcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_function_index,
   input  logic [7:0]  req_offset,
   input  logic [7:0]  req_write_data,
   input  ctrl_type    ctl,
   output status_type  sts,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_event_valid,
   output logic [2:0]  rsp_event_region,
   output logic        rsp_event_active,
   output logic [31:0] rsp_event_base,
   output logic        rsp_last
);

   logic [1:0]  cmd_ff;
   logic [2:0]  fn_ff;
   logic [7:0]  off_ff, wd_ff;

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic        rvld_ff;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [7:0]  cmdb_ff [FUNCTIONS];
   logic [7:0]  cmdb_in [FUNCTIONS];
   logic [7:0]  cmdb_sel;

   logic [NEV-1:0] mask_ff, mask_in, mask_mod, lowbit;
   evm_type     mode_ff, mode_in, mode_mod;
   logic [3:0]  idx;
   logic [2:0]  region;

   logic [6:0]  present, io7, pf7;
   logic [4:0]  codes [NREG];
   logic        fn_ok, bar_hit, rom_hit, cmd_hit;
   act_type     act;
   logic [2:0]  bar_r;
   logic [1:0]  lane;
   logic [31:0] d_old, set_d, new_d, nd, def_raw, def_d, keep32;
   logic [7:0]  old_byte, keep8, byte_v, diff, rd_byte;

   logic        wr_en, rd_en;
   addr_type    wr_addr, rd_addr;
   logic [31:0] wr_data;

   logic        emit;
   logic        rsp_valid_ff, ev_valid_ff, ev_active_ff, last_ff;
   logic [7:0]  rd_data_ff;
   logic [2:0]  ev_region_ff;
   logic [31:0] ev_base_ff;
   logic [7:0]  o_rd;
   logic        o_ev, o_act, o_last;
   logic [2:0]  o_reg;
   logic [31:0] o_base;

   assign present = cfg.region_flags[6:0];
   assign io7     = {1'b0, cfg.region_flags[12:7]};
   assign pf7     = {1'b0, cfg.region_flags[18:13]};

   always_comb begin
      for (int i = 0; i < NREG; i++) codes[i] = cfg.size_codes[5*i +: 5];
   end

   assign fn_ok   = {1'b0, fn_ff} < 4'(FUNCTIONS);
   assign bar_hit = (off_ff inside {[8'h10:8'h27]});
   assign rom_hit = (off_ff inside {[8'h30:8'h33]});
   assign cmd_hit = (off_ff == 8'h04);
   assign bar_r   = 3'((off_ff - 8'h10) >> 2);
   assign lane    = off_ff[1:0];
   assign d_old   = rvld_ff ? rdata_ff : 32'h0;

   always_comb begin
      act = ACT_NONE;
      if (cmd_ff == CMD_READ) begin
         act = ACT_READ;
      end else if (fn_ok && cmd_ff == CMD_WRITE) begin
         if (read_only(off_ff)) act = ACT_NONE;
         else if (bar_hit && !present[bar_r]) act = ACT_NONE;
         else if (rom_hit && !present[ROM_REG]) act = ACT_NONE;
         else act = ACT_RMW;
      end else if (fn_ok && cmd_ff == CMD_RESET) begin
         act = ACT_RESET;
      end
   end

   always_comb begin
      cmdb_sel = 8'h0;
      for (int i = 0; i < FUNCTIONS; i++)
         if (fn_ff == 3'(i)) cmdb_sel = cmdb_ff[i];
   end

   // byte merge and BAR / ROM alignment
   always_comb begin
      old_byte = d_old[8*lane +: 8];
      keep8    = io7[bar_r] ? ~KEEP_IO : ~KEEP_MEM;
      keep32   = {24'h0, keep8};
      if (bar_hit && lane == 2'd0) byte_v = (old_byte & keep8) | (wd_ff & ~keep8);
      else byte_v = wd_ff;
      set_d = put_byte(d_old, lane, byte_v);
      nd    = (d_old & ROM_KEEP_OLD) | (set_d & ROM_KEEP_NEW);
      if (bar_hit)
         new_d = (set_d & ~keep32 & align_mask(codes[bar_r])) | (set_d & keep32);
      else if (rom_hit)
         new_d = (nd & ROM_ADDR & align_mask(codes[ROM_REG])) | (nd & ROM_LOW);
      else
         new_d = set_d;
   end

   always_comb begin
      diff     = wd_ff ^ cmdb_sel;
      mask_mod = '0;
      mode_mod = EVM_CMD;
      if (cmd_hit) begin
         mask_mod = {diff[1] ? (present & ~io7) : 7'h0, diff[0] ? (present & io7) : 7'h0};
      end else if (bar_hit) begin
         mode_mod = EVM_BAR;
         if (lane == 2'd3 && (io7[bar_r] ? cmdb_sel[0] : cmdb_sel[1]))
            mask_mod = NEV'(1) << bar_r;
      end else if (rom_hit) begin
         mode_mod = EVM_ROM;
         if (lane == 2'd3) mask_mod = NEV'(1) << ROM_REG;
      end
   end

   always_comb begin
      idx = '0;
      for (int i = NEV - 1; i >= 0; i--)
         if (mask_ff[i]) idx = 4'(i);
      region = (idx >= 4'(NREG)) ? 3'(idx - 4'(NREG)) : 3'(idx);
      lowbit = mask_ff & (~mask_ff + NEV'(1));
   end

   always_comb begin
      mask_in = mask_ff;
      mode_in = mode_ff;
      if (ctl.clr_fn) begin
         mask_in = {7'h0, present};
         mode_in = EVM_RST;
      end else if (ctl.wr_mod) begin
         mask_in = mask_mod;
         mode_in = mode_mod;
      end else if (ctl.emit_ev) begin
         mask_in = mask_ff & ~lowbit;
      end
   end

   always_comb begin
      case (region)
         3'd0:    def_raw = cfg.def01[31:0];
         3'd1:    def_raw = cfg.def01[63:32];
         3'd2:    def_raw = cfg.def23[31:0];
         3'd3:    def_raw = cfg.def23[63:32];
         3'd4:    def_raw = cfg.def45[31:0];
         3'd5:    def_raw = cfg.def45[63:32];
         default: def_raw = cfg.defrom;
      endcase
      if (region == ROM_REG) def_d = def_raw & ROM_ADDR;
      else if (io7[region]) def_d = (def_raw & MASK_IO) | 32'h1;
      else def_d = (def_raw & MASK_MEM) | {28'h0, pf7[region], 3'b000};
   end

   assign wr_en   = ctl.wr_mod || ctl.wr_def;
   assign wr_addr = ctl.wr_def ? addr_of(fn_ff, dword_of(region)) : addr_of(fn_ff, off_ff[7:2]);
   assign wr_data = ctl.wr_def ? def_d : new_d;
   assign rd_en   = ctl.rd_ofs || ctl.rd_reg;
   assign rd_addr = ctl.rd_reg ? addr_of(fn_ff, dword_of(region)) : addr_of(fn_ff, off_ff[7:2]);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         rvld_ff  <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (ctl.clr_fn)
         for (int i = 0; i < DEPTH; i++)
            if (3'(i >> 6) == fn_ff && clears_on_reset(6'(i))) vld_in[i] = 1'b0;
      if (wr_en) vld_in[wr_addr] = 1'b1;
   end

   always_comb begin
      for (int i = 0; i < FUNCTIONS; i++) begin
         cmdb_in[i] = cmdb_ff[i];
         if (fn_ff == 3'(i) && ctl.clr_fn) cmdb_in[i] = 8'h0;
         if (fn_ff == 3'(i) && ctl.wr_mod && cmd_hit) cmdb_in[i] = wd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         mask_ff <= '0;
         mode_ff <= EVM_CMD;
         for (int i = 0; i < FUNCTIONS; i++) cmdb_ff[i] <= 8'h0;
      end else begin
         vld_ff  <= vld_in;
         mask_ff <= mask_in;
         mode_ff <= mode_in;
         for (int i = 0; i < FUNCTIONS; i++) cmdb_ff[i] <= cmdb_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= req_cmd;
         fn_ff  <= req_function_index;
         off_ff <= req_offset;
         wd_ff  <= req_write_data;
      end
   end

   always_comb begin
      if (!fn_ok) rd_byte = 8'hFF;
      else if (off_ff inside {[8'h00:8'h03]}) rd_byte = cfg.id_word[8*lane +: 8];
      else if (off_ff inside {[8'h08:8'h0B]}) rd_byte = cfg.class_word[8*lane +: 8];
      else rd_byte = d_old[8*lane +: 8];
   end

   always_comb begin
      o_rd   = 8'h0;
      o_ev   = 1'b0;
      o_reg  = 3'd0;
      o_act  = 1'b0;
      o_base = 32'h0;
      o_last = 1'b1;
      if (ctl.emit_rd) begin
         o_rd = rd_byte;
      end else if (ctl.emit_ev) begin
         o_ev   = 1'b1;
         o_reg  = region;
         o_base = io7[region] ? (d_old & MASK_IO) : (d_old & MASK_MEM);
         o_last = sts.ev_last;
         case (mode_ff)
            EVM_CMD: o_act = (idx >= 4'(NREG)) ? wd_ff[1] : wd_ff[0];
            EVM_BAR: o_act = 1'b1;
            EVM_ROM: o_act = d_old[0];
            default: o_act = 1'b0;
         endcase
      end
   end

   assign emit = ctl.emit_rd || ctl.emit_ev || ctl.emit_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rd_data_ff   <= o_rd;
         ev_valid_ff  <= o_ev;
         ev_region_ff <= o_reg;
         ev_active_ff <= o_act;
         ev_base_ff   <= o_base;
         last_ff      <= o_last;
      end
   end

   assign sts.act        = act;
   assign sts.mod_events = |mask_in;
   assign sts.ev_last    = ((mask_ff & ~lowbit) == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rd_data_ff;
   assign rsp_event_valid  = ev_valid_ff;
   assign rsp_event_region = ev_region_ff;
   assign rsp_event_active = ev_active_ff;
   assign rsp_event_base   = ev_base_ff;
   assign rsp_last         = last_ff;

endmodule

[rtl/pci_config_space_unit.sv]
// ----------------------------------------------------------------------------
// pci_config_space_unit
// Byte-wide PCI type-0 configuration space with region change events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  req_    | in        | req_valid/req_stall  | cmd, function, offset, data
//  rsp_    | out       | rsp_valid/rsp_stall  | read byte, region event, last
//  csr     | in        | APB psel/penable     | 64-bit configuration register
//
//  One request at a time. Read: fetch, then result. Write: fetch, modify,
//  then an empty result or per event a store read and emit. Function reset:
//  clear, then per present region a load, read and emit (else empty result).
//  Function reset clears resettable dwords at once by per-dword valid bits.
//  A stalled result holds the sequencer at its emit step.
// ----------------------------------------------------------------------------
module pci_config_space_unit
   import pcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_function_index,
   input  logic [7:0]  req_offset,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_event_valid,
   output logic [2:0]  rsp_event_region,
   output logic        rsp_event_active,
   output logic [31:0] rsp_event_base,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   ctrl_type   ctl;
   status_type sts;

   pcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   pcs_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_cmd            (req_cmd),
      .req_function_index (req_function_index),
      .req_offset         (req_offset),
      .req_write_data     (req_write_data),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_read_data      (rsp_read_data),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_event_region   (rsp_event_region),
      .rsp_event_active   (rsp_event_active),
      .rsp_event_base     (rsp_event_base),
      .rsp_last           (rsp_last)
   );

endmodule

[rtl/pcs_checker.sv]
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks of the PCI configuration space unit.
// ----------------------------------------------------------------------------
`include "pci_config_space_unit_defines.svh"

module pcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_event_valid,
   input logic [2:0]  rsp_event_region,
   input logic        rsp_event_active,
   input logic [31:0] rsp_event_base,
   input logic        rsp_last
);

   `PCS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `PCS_ASSERT_NOW(a_empty_event_zero, rsp_valid && !rsp_event_valid, rsp_event_region == 3'd0 && !rsp_event_active && rsp_event_base == 32'h0)
   `PCS_ASSERT_NOW(a_event_no_data, rsp_valid && rsp_event_valid, rsp_read_data == 8'h0 && rsp_event_region != 3'd7)
   `PCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_last) && $stable(rsp_event_base))

endmodule

bind pci_config_space_unit pcs_checker u_pcs_checker (.*);

[tb/pci_config_space_unit_test.sv]
// ----------------------------------------------------------------------------
// pci_config_space_unit_test
// Drives reads, writes and function resets of the configuration space under
// random burst gaps and result stalls, across several register settings, and
// checks every result word against an in-bench model of the byte store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pci_config_space_unit_test;
   import pcs_pkg::*;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        event_valid;
      logic [2:0]  event_region;
      logic        event_active;
      logic [31:0] event_base;
      logic        last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_READ;
   logic [2:0]  req_function_index = 3'd0;
   logic [7:0]  req_offset = 8'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_event_valid;
   logic [2:0]  rsp_event_region;
   logic        rsp_event_active;
   logic [31:0] rsp_event_base;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = 6'd0;
   logic [63:0] pwdata = 64'd0;
   logic [63:0] prdata;
   logic        pready;

   pci_config_space_unit i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cfg_type      regs;
   logic [31:0]  space [DEPTH];
   rsp_word_type expected_words [$];
   int           mismatches = 0;
   int           burst_left = 0;

   function automatic logic present(input int r);
      return regs.region_flags[r];
   endfunction
   function automatic logic is_io(input int r);
      return r < 6 && regs.region_flags[7+r];
   endfunction
   function automatic logic [31:0] amask(input int r);
      return ~32'h0 << regs.size_codes[5*r +: 5];
   endfunction
   function automatic int dw_of(input int r);
      return r == 6 ? 12 : 4 + r;
   endfunction
   function automatic logic [7:0] byte_at(input int f, input int off);
      return space[f*64 + off/4][8*(off%4) +: 8];
   endfunction
   function automatic logic ro_byte(input int off);
      return off <= 3 || (off >= 8 && off <= 15) || (off >= 44 && off <= 47) ||
             (off >= 52 && off <= 59) || off == 62 || off == 63;
   endfunction

   task automatic push_event(input int f, input int r, input logic act);
      rsp_word_type w;
      logic [31:0] d;
      d = space[f*64 + dw_of(r)];
      w = '0;
      w.event_valid = 1'b1;
      w.event_region = 3'(r);
      w.event_active = act;
      w.event_base = is_io(r) ? (d & MASK_IO) : (d & MASK_MEM);
      expected_words.push_back(w);
   endtask

   task automatic predict_word(input logic [1:0] cmd, input int f, input int off,
                               input logic [7:0] v);
      rsp_word_type w;
      int n0, r, i;
      logic [7:0] old, keep;
      logic [31:0] d, nd, def;
      n0 = expected_words.size();
      if (cmd == CMD_READ) begin
         w = '0;
         if (f >= FUNCTIONS) w.read_data = 8'hFF;
         else if (off <= 3) w.read_data = regs.id_word[8*off +: 8];
         else if (off >= 8 && off <= 11) w.read_data = regs.class_word[8*(off-8) +: 8];
         else w.read_data = byte_at(f, off);
         expected_words.push_back(w);
      end else if (f < FUNCTIONS && cmd == CMD_WRITE && !ro_byte(off)) begin
         if (off == 4) begin
            old = byte_at(f, 4);
            space[f*64+1][7:0] = v;
            if ((v ^ old) & 8'd1)
               for (r = 0; r < 7; r++) if (present(r) && is_io(r)) push_event(f, r, v[0]);
            if ((v ^ old) & 8'd2)
               for (r = 0; r < 7; r++) if (present(r) && !is_io(r)) push_event(f, r, v[1]);
         end else if (off >= 16 && off <= 39) begin
            r = (off - 16) / 4;
            if (present(r)) begin
               keep = is_io(r) ? 8'h03 : 8'h0F;
               if (off % 4 == 0) v = (byte_at(f, off) & keep) | (v & ~keep);
               space[f*64 + off/4][8*(off%4) +: 8] = v;
               d = space[f*64 + off/4];
               space[f*64 + off/4] = (d & ~32'(keep) & amask(r)) | (d & 32'(keep));
               if (off % 4 == 3 && (byte_at(f, 4) & (is_io(r) ? 8'd1 : 8'd2)))
                  push_event(f, r, 1'b1);
            end
         end else if (off >= 48 && off <= 51) begin
            if (present(6)) begin
               d = space[f*64+12];
               space[f*64+12][8*(off%4) +: 8] = v;
               nd = (d & ROM_KEEP_OLD) | (space[f*64+12] & ROM_KEEP_NEW);
               space[f*64+12] = (nd & ROM_ADDR & amask(6)) | (nd & ROM_LOW);
               if (off == 51) push_event(f, 6, space[f*64+12][0]);
            end
         end else begin
            space[f*64 + off/4][8*(off%4) +: 8] = v;
         end
      end else if (f < FUNCTIONS && cmd == CMD_RESET) begin
         for (i = 0; i < 64; i++)
            if (i == 1 || (i >= 4 && i <= 10) || i == 12 || i >= 16) space[f*64+i] = 0;
         for (r = 0; r < 7; r++) if (present(r)) begin
            if (r == 6) def = regs.defrom;
            else if (r < 2) def = regs.def01[32*(r%2) +: 32];
            else if (r < 4) def = regs.def23[32*(r%2) +: 32];
            else def = regs.def45[32*(r%2) +: 32];
            if (r == 6) d = def & ROM_ADDR;
            else if (is_io(r)) d = (def & MASK_IO) | 32'd1;
            else d = (def & MASK_MEM) | (regs.region_flags[13+r] ? 32'd8 : 32'd0);
            space[f*64 + dw_of(r)] = d;
            push_event(f, r, 1'b0);
         end
      end
      if (expected_words.size() == n0) expected_words.push_back('0);
      expected_words[$].last = 1'b1;
   endtask

   // receiver stall pattern
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 9) < 3) && ($urandom_range(0, 3) != 0);

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_read_data, rsp_event_valid, rsp_event_region, rsp_event_active,
                rsp_event_base, rsp_last};
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch exp %h got %h", want, got);
            end
         end
      end
   end

   task automatic send_word(input logic [1:0] cmd, input logic [2:0] f, input logic [7:0] off,
                            input logic [7:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      predict_word(cmd, f, off, v);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_function_index <= f;
      req_offset <= off;
      req_write_data <= v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'd0}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         CSR_ID: regs.id_word = val[31:0];
         CSR_CLASS: regs.class_word = val[31:0];
         CSR_FLAGS: regs.region_flags = val[18:0];
         CSR_CODES: regs.size_codes = val[34:0];
         CSR_DEF01: regs.def01 = val;
         CSR_DEF23: regs.def23 = val;
         CSR_DEF45: regs.def45 = val;
         default: regs.defrom = val[31:0];
      endcase
   endtask

   task automatic load_regs(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c,
                            input logic [63:0] d);
      csr_write(CSR_ID, a);
      csr_write(CSR_CLASS, b);
      csr_write(CSR_FLAGS, c);
      csr_write(CSR_CODES, d);
      csr_write(CSR_DEF01, {$urandom, $urandom});
      csr_write(CSR_DEF23, {$urandom, $urandom});
      csr_write(CSR_DEF45, {$urandom, $urandom});
      csr_write(CSR_DEFROM, 64'($urandom));
   endtask

   // a write is accepted only if the offset is writable somewhere; pick mostly
   // header bytes so that BAR, ROM and command paths are exercised
   function automatic logic [7:0] pick_offset;
      case ($urandom_range(0, 5))
         0: return 8'h04;
         1, 2: return 8'(8'h10 + $urandom_range(0, 23));
         3: return 8'(8'h30 + $urandom_range(0, 3));
         4: return 8'($urandom_range(0, 63));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_directed;
      int i;
      send_word(CMD_RESET, 3'd0, 8'd0, 8'd0);
      for (i = 0; i < 4; i++) send_word(CMD_READ, 3'd0, 8'(i), 8'd0);
      send_word(CMD_READ, 3'd0, 8'h0B, 8'd0);
      send_word(CMD_WRITE, 3'd0, 8'h00, 8'hFF);
      send_word(CMD_WRITE, 3'd0, 8'h3F, 8'hFF);
      send_word(CMD_READ, 3'd0, 8'h3F, 8'd0);
      send_word(CMD_WRITE, 3'd0, 8'h04, 8'h03);
      send_word(CMD_WRITE, 3'd0, 8'h10, 8'hFF);
      send_word(CMD_WRITE, 3'd0, 8'h13, 8'hFF);
      send_word(CMD_WRITE, 3'd0, 8'h14, 8'h00);
      send_word(CMD_WRITE, 3'd0, 8'h30, 8'hFF);
      send_word(CMD_WRITE, 3'd0, 8'h33, 8'hFF);
      send_word(CMD_READ, 3'd0, 8'h30, 8'd0);
      send_word(CMD_WRITE, 3'd0, 8'h04, 8'h00);
      send_word(CMD_WRITE, 3'd0, 8'hFF, 8'hA5);
      send_word(CMD_READ, 3'd0, 8'hFF, 8'd0);
      send_word(CMD_READ, 3'd7, 8'h10, 8'd0);
      send_word(CMD_WRITE, 3'd7, 8'h40, 8'h55);
      send_word(CMD_RESET, 3'd7, 8'd0, 8'd0);
      send_word(CMD_NOP, 3'd0, 8'h40, 8'h00);
      send_word(CMD_RESET, 3'd0, 8'hFF, 8'hFF);
      drain();
   endtask

   task automatic test_random(input int count);
      int i;
      logic [1:0] c;
      for (i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: c = CMD_RESET;
            1: c = CMD_NOP;
            2, 3, 4, 5, 6, 7: c = CMD_READ;
            default: c = CMD_WRITE;
         endcase
         send_word(c, ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'd0,
                   ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_offset(),
                   8'($urandom));
      end
      drain();
   endtask

   initial begin
      int i;
      for (i = 0; i < DEPTH; i++) space[i] = 32'd0;
      regs = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_regs(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h7FFFF, 64'h7_FFFF_FFFF);
      test_directed();
      load_regs(64'($urandom), 64'($urandom), 64'h0007F, {30'd0, 5'd11, {6{5'd4}}});
      test_directed();
      load_regs(64'h0, 64'h0, 64'h0, 64'h0);
      test_random(30);
      load_regs(64'($urandom), 64'($urandom), 64'($urandom_range(0, 524287)),
                {$urandom, $urandom});
      test_random(70);
      load_regs(64'($urandom), 64'($urandom), 64'h7FFFF,
                {29'd0, 6'($urandom_range(0, 31)), 30'($urandom)});
      test_random(70);
      load_regs(64'($urandom), 64'($urandom), 64'h0FC7F, {$urandom, $urandom});
      test_random(64);
      if (mismatches == 0 && expected_words.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule

[pci_config_space_unit.f]
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_csr.sv
rtl/pcs_ctrl.sv
rtl/pcs_dp.sv
rtl/pci_config_space_unit.sv
rtl/pcs_checker.sv
tb/pci_config_space_unit_test.sv
